// File: rtl/qrr_pkg.sv
// Shared constants and types for the Q32.32 rotation recurrence block.
`default_nettype none

package qrr_pkg;

	localparam int unsigned QW       = 64;
	localparam int unsigned HALF_W   = QW / 2;
	localparam int unsigned ACC_W    = QW + HALF_W;
	localparam int unsigned PP_W     = 2 * (HALF_W + 1);
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [QW-1:0] Q_ONE   = 64'h0000_0001_0000_0000;
	localparam logic [QW-1:0] Q_THREE = 64'h0000_0003_0000_0000;

	// Operation codes carried in the func field.
	localparam logic [1:0] FUNC_RESTART   = 2'd0;
	localparam logic [1:0] FUNC_STEP      = 2'd1;
	localparam logic [1:0] FUNC_APPLY     = 2'd2;
	localparam logic [1:0] FUNC_NORMALIZE = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_SINE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_COSINE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_SINE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_COSINE  = 3'd5;

	// Partial product selector: bit 1 picks the upper half of a, bit 0 of b.
	localparam logic [1:0] PART_LL   = 2'b00;
	localparam logic [1:0] PART_HH   = 2'b11;
	localparam logic [1:0] PART_LAST = 2'b11;

	typedef struct packed {
		logic       load_in;
		logic       clr;
		logic       mul_en;
		logic [1:0] part;
		logic       pass;
		logic       save_tmp;
		logic       finish;
	} ctrl_cmd_t;

endpackage

`default_nettype wire

// File: rtl/qrr_mul_lane.sv
// One multiply lane: a 33x33 signed multiplier that builds a Q32 product over four partials.
`default_nettype none

module qrr_mul_lane
	import qrr_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          clr,
	input  wire logic          mul_en,
	input  wire logic [1:0]    part,
	input  wire logic [QW-1:0] a,
	input  wire logic [QW-1:0] b,
	output logic [QW-1:0]      prod
);

	logic signed [HALF_W:0]   a_op;
	logic signed [HALF_W:0]   b_op;
	logic signed [PP_W-1:0]   pp;
	logic signed [PP_W-1:0]   pp_s1;
	logic [1:0]               part_s1;
	logic                     pp_v_s1;
	logic [ACC_W-1:0]         pp_ext;
	logic [ACC_W-1:0]         addend;
	logic [ACC_W-1:0]         acc_q;

	// Low halves are unsigned, high halves carry the sign of the operand.
	always_comb begin
		a_op = part[1] ? {a[QW-1], a[QW-1:HALF_W]} : {1'b0, a[HALF_W-1:0]};
		b_op = part[0] ? {b[QW-1], b[QW-1:HALF_W]} : {1'b0, b[HALF_W-1:0]};
		pp   = a_op * b_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp_v_s1 <= 1'b0;
		end else begin
			pp_v_s1 <= mul_en;
		end
	end

	always_ff @(posedge clk) begin
		pp_s1   <= pp;
		part_s1 <= part;
	end

	// Weight of each partial: 2^0, 2^32 or 2^64, taken modulo 2^96.
	always_comb begin
		pp_ext = {{(ACC_W-PP_W){pp_s1[PP_W-1]}}, pp_s1};
		case (part_s1)
			PART_LL: addend = pp_ext;
			PART_HH: addend = pp_ext << QW;
			default: addend = pp_ext << HALF_W;
		endcase
	end

	always_ff @(posedge clk) begin
		if (clr) begin
			acc_q <= '0;
		end else if (pp_v_s1) begin
			acc_q <= acc_q + addend;
		end
	end

	assign prod = acc_q[ACC_W-1:HALF_W];

endmodule

`default_nettype wire

// File: rtl/qrr_datapath.sv
// Datapath: configuration and state registers, two multiply lanes, combine logic and result registers.
`default_nettype none

module qrr_datapath
	import qrr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ctrl_cmd_t            cmd,
	input  wire logic [1:0]           func,
	input  wire logic [QW-1:0]        x_in,
	input  wire logic [QW-1:0]        y_in,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [QW-1:0]        cfg_data,
	output logic [QW-1:0]             x_out,
	output logic [QW-1:0]             y_out,
	output logic [QW-1:0]             sine_now,
	output logic [QW-1:0]             cosine_now,
	output logic [QW-1:0]             angle_now
);

	logic [QW-1:0] start_angle_q, start_sine_q, start_cosine_q;
	logic [QW-1:0] angle_step_q, step_sine_q, step_cosine_q;
	logic [QW-1:0] sine_q, cosine_q, angle_q;
	logic [1:0]    func_q;
	logic [QW-1:0] x_q, y_q, tmp_q;
	logic [QW-1:0] a_lane0, b_lane0, a_lane1, b_lane1;
	logic [QW-1:0] prod0, prod1;
	logic [QW-1:0] sum01, dif01, diff3;
	logic [QW-1:0] tmp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_angle_q  <= '0;
			start_sine_q   <= '0;
			start_cosine_q <= Q_ONE;
			angle_step_q   <= '0;
			step_sine_q    <= '0;
			step_cosine_q  <= Q_ONE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_ANGLE:  start_angle_q  <= cfg_data;
				CFG_START_SINE:   start_sine_q   <= cfg_data;
				CFG_START_COSINE: start_cosine_q <= cfg_data;
				CFG_ANGLE_STEP:   angle_step_q   <= cfg_data;
				CFG_STEP_SINE:    step_sine_q    <= cfg_data;
				CFG_STEP_COSINE:  step_cosine_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q <= func;
			x_q    <= x_in;
			y_q    <= y_in;
		end
	end

	// Operand routing. The first pass of step and apply forms the sine or x term,
	// the second the cosine or y term; normalize first forms s^2 + c^2.
	always_comb begin
		a_lane0 = sine_q;
		b_lane0 = step_cosine_q;
		a_lane1 = cosine_q;
		b_lane1 = step_sine_q;
		case (func_q)
			FUNC_STEP: begin
				a_lane0 = cmd.pass ? cosine_q : sine_q;
				b_lane0 = step_cosine_q;
				a_lane1 = cmd.pass ? sine_q : cosine_q;
				b_lane1 = step_sine_q;
			end
			FUNC_APPLY: begin
				a_lane0 = x_q;
				b_lane0 = cmd.pass ? sine_q : cosine_q;
				a_lane1 = y_q;
				b_lane1 = cmd.pass ? cosine_q : sine_q;
			end
			FUNC_NORMALIZE: begin
				a_lane0 = sine_q;
				b_lane0 = cmd.pass ? tmp_q : sine_q;
				a_lane1 = cosine_q;
				b_lane1 = cmd.pass ? tmp_q : cosine_q;
			end
			default: ;
		endcase
	end

	qrr_mul_lane u_lane0 (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (cmd.clr),
		.mul_en (cmd.mul_en),
		.part   (cmd.part),
		.a      (a_lane0),
		.b      (b_lane0),
		.prod   (prod0)
	);

	qrr_mul_lane u_lane1 (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (cmd.clr),
		.mul_en (cmd.mul_en),
		.part   (cmd.part),
		.a      (a_lane1),
		.b      (b_lane1),
		.prod   (prod1)
	);

	// The normalize scale is halved with an arithmetic shift, rounding toward minus infinity.
	always_comb begin
		sum01 = prod0 + prod1;
		dif01 = prod0 - prod1;
		diff3 = Q_THREE - sum01;
		case (func_q)
			FUNC_APPLY:     tmp_d = dif01;
			FUNC_NORMALIZE: tmp_d = {diff3[QW-1], diff3[QW-1:1]};
			default:        tmp_d = sum01;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.save_tmp) begin
			tmp_q <= tmp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sine_q   <= '0;
			cosine_q <= Q_ONE;
			angle_q  <= '0;
		end else if (cmd.finish) begin
			case (func_q)
				FUNC_RESTART: begin
					sine_q   <= start_sine_q;
					cosine_q <= start_cosine_q;
					angle_q  <= start_angle_q;
				end
				FUNC_STEP: begin
					sine_q   <= tmp_q;
					cosine_q <= dif01;
					angle_q  <= angle_q + angle_step_q;
				end
				FUNC_NORMALIZE: begin
					sine_q   <= prod0;
					cosine_q <= prod1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			case (func_q)
				FUNC_RESTART: begin
					x_out      <= '0;
					y_out      <= '0;
					sine_now   <= start_sine_q;
					cosine_now <= start_cosine_q;
					angle_now  <= start_angle_q;
				end
				FUNC_STEP: begin
					x_out      <= '0;
					y_out      <= '0;
					sine_now   <= tmp_q;
					cosine_now <= dif01;
					angle_now  <= angle_q + angle_step_q;
				end
				FUNC_APPLY: begin
					x_out      <= tmp_q;
					y_out      <= sum01;
					sine_now   <= sine_q;
					cosine_now <= cosine_q;
					angle_now  <= angle_q;
				end
				FUNC_NORMALIZE: begin
					x_out      <= '0;
					y_out      <= '0;
					sine_now   <= prod0;
					cosine_now <= prod1;
					angle_now  <= angle_q;
				end
				default: begin
					x_out      <= '0;
					y_out      <= '0;
					sine_now   <= sine_q;
					cosine_now <= cosine_q;
					angle_now  <= angle_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/qrr_ctrl.sv
// Controller state machine: handshakes, pass and partial product sequencing.
`default_nettype none

module qrr_ctrl
	import qrr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] func,
	output logic            out_valid,
	input  wire logic       out_ready,
	output ctrl_cmd_t       cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_MUL   = 5'b00010,
		S_DRAIN = 5'b00100,
		S_PASS  = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] part_q, part_d;
	logic       pass_q, pass_d;
	logic       out_valid_q;

	always_comb begin
		state_d  = state_q;
		part_d   = part_q;
		pass_d   = pass_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.part = part_q;
		cmd.pass = pass_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					cmd.clr     = 1'b1;
					part_d      = '0;
					pass_d      = 1'b0;
					state_d     = (func == FUNC_RESTART) ? S_FIN : S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				part_d     = part_q + 2'd1;
				if (part_q == PART_LAST) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = pass_q ? S_FIN : S_PASS;
			end
			S_PASS: begin
				cmd.save_tmp = 1'b1;
				cmd.clr      = 1'b1;
				pass_d       = 1'b1;
				part_d       = '0;
				state_d      = S_MUL;
			end
			S_FIN: begin
				// The result register must be free before it is overwritten.
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			part_q      <= '0;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			part_q  <= part_d;
			pass_q  <= pass_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while still held");

	a_restart_direct: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && func == FUNC_RESTART) |=> (state_q == S_FIN))
		else $error("restart did not go straight to finish");

	a_mul_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && func != FUNC_RESTART) |=>
			(state_q == S_MUL && part_q == PART_LL && !pass_q))
		else $error("multiply sequence did not start at the first partial");

	a_drain_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |-> ($past(cmd.mul_en) && $past(part_q) == PART_LAST))
		else $error("drain entered before all partials were issued");

endmodule

`default_nettype wire

// File: rtl/q32_rotation_recurrence_top.sv
// Top level of the Q32.32 rotation recurrence: sine, cosine and angle kept by complex rotation.
//
// Input channel (in_valid/in_ready) carries func, x_in and y_in. func selects restart (load
// state from the start registers), step (rotate by the step sine and cosine, add angle_step),
// apply (rotate the point x_in, y_in by the current angle) or normalize (rescale sine and
// cosine by (3 - (s^2 + c^2)) / 2). Each transaction yields exactly one result transaction on
// out_valid/out_ready with x_out, y_out (zero except for apply) and the state after the
// operation.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready and
// writes one of six 64-bit registers; indexes six and seven are ignored. Write it only while
// the block is idle.
// Sequence: restart goes from acceptance straight to the finish step. The other operations
// run two passes through two 33x33 multiply lanes of four partial products, each pass followed
// by a drain step, with a combine step between the passes, then a finish step and a return to
// idle. The Q32 product built over four partials in each lane sets the length of this sequence.
// The result sits in an output register, so a new transaction is accepted while the previous
// result waits; a stalled receiver holds the block in its finish step until the register frees.
// Reset clears the state to sine 0, cosine 1.0, angle 0 and loads the register defaults.
`default_nettype none

module q32_rotation_recurrence_top
	import qrr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           func,
	input  wire logic [QW-1:0]        x_in,
	input  wire logic [QW-1:0]        y_in,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [QW-1:0]             x_out,
	output logic [QW-1:0]             y_out,
	output logic [QW-1:0]             sine_now,
	output logic [QW-1:0]             cosine_now,
	output logic [QW-1:0]             angle_now,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [QW-1:0]        cfg_data
);

	ctrl_cmd_t cmd;

	assign cfg_ready = 1'b1;

	qrr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	qrr_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.func       (func),
		.x_in       (x_in),
		.y_in       (y_in),
		.cfg_we     (cfg_valid & cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.x_out      (x_out),
		.y_out      (y_out),
		.sine_now   (sine_now),
		.cosine_now (cosine_now),
		.angle_now  (angle_now)
	);

endmodule

`default_nettype wire
